// File: rtl/core/puas_pkg.sv
// Shared types, widths and helpers for the periodic upwind advection step.
// No dependencies; imported by puas_front, puas_back and the top level.
package puas_pkg;

    localparam int PIX_W          = 6;
    localparam int Q_W            = 24;
    localparam int GAIN_W         = 16;
    localparam int CNT_W          = 7;
    localparam int PROD_W         = Q_W + 1 + GAIN_W + 1;
    localparam int SUM_W          = Q_W + 3;
    localparam int DEF_MAX_POINTS = 64;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    localparam logic [CNT_W-1:0] POINTS_RST = 7'd64;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_STEP    = 1'b1;
    // register select is paddr[2]
    localparam logic REG_POINTS = 1'b0;

    localparam logic signed [SUM_W-1:0] SAT_HI = 27'sd8388607;
    localparam logic signed [SUM_W-1:0] SAT_LO = -27'sd8388608;

    typedef struct packed {
        logic                     op;
        logic [PIX_W-1:0]         idx;
        logic signed [Q_W-1:0]    u;
        logic signed [Q_W-1:0]    v;
        logic [GAIN_W-1:0]        alpha;
        logic [GAIN_W-1:0]        beta;
        logic                     emit;
    } t_cmd;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] x);
        logic signed [Q_W-1:0] r;
        if (x > SAT_HI) begin
            r = SAT_HI[Q_W-1:0];
        end else if (x < SAT_LO) begin
            r = SAT_LO[Q_W-1:0];
        end else begin
            r = x[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/puas_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module puas_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]          i_wdata,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/puas_front.sv
// Front end: takes input transfers, drops out-of-range loads, queues commands.
// Depends on puas_pkg.
module puas_front #(
    parameter int MAX_POINTS = puas_pkg::DEF_MAX_POINTS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_opcode,
    input  logic [puas_pkg::PIX_W-1:0]           i_point_index,
    input  logic signed [puas_pkg::Q_W-1:0]      i_load_u,
    input  logic signed [puas_pkg::Q_W-1:0]      i_load_v,
    input  logic [puas_pkg::GAIN_W-1:0]          i_advect_gain,
    input  logic [puas_pkg::GAIN_W-1:0]          i_relax_gain,
    input  logic                                 i_emit_after,
    output logic                                 o_cmd_valid,
    output puas_pkg::t_cmd                       o_cmd,
    input  logic                                 i_cmd_pop
);
    import puas_pkg::*;

    localparam logic [CNT_W-1:0] MAXP = CNT_W'(MAX_POINTS);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       accept;
    logic       keep;
    t_cmd       cmd_in;

    assign accept = i_valid && !o_stall;
    assign keep   = accept && ((i_opcode == OP_STEP) || ({1'b0, i_point_index} < MAXP));

    always_comb begin
        cmd_in.op    = i_opcode;
        cmd_in.idx   = i_point_index;
        cmd_in.u     = i_load_u;
        cmd_in.v     = i_load_v;
        cmd_in.alpha = i_advect_gain;
        cmd_in.beta  = i_relax_gain;
        cmd_in.emit  = i_emit_after;
    end

    always_comb begin
        n_cnt = r_cnt + {1'b0, keep} - {1'b0, i_cmd_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (keep) begin
                r_wp <= !r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

endmodule

// File: rtl/core/puas_back.sv
// Back end: grid store, load writes, upwind sweep pipeline and point streaming.
// Depends on puas_pkg and puas_ram.
module puas_back #(
    parameter int MAX_POINTS = puas_pkg::DEF_MAX_POINTS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [puas_pkg::CNT_W-1:0]           i_points,
    input  logic                                 i_cmd_valid,
    input  puas_pkg::t_cmd                       i_cmd,
    output logic                                 o_cmd_pop,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [puas_pkg::PIX_W-1:0]           o_out_index,
    output logic signed [puas_pkg::Q_W-1:0]      o_out_u,
    output logic signed [puas_pkg::Q_W-1:0]      o_out_v,
    output logic                                 o_last_point
);
    import puas_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int DW = 2 * Q_W;
    localparam logic [CNT_W-1:0] MAXP = CNT_W'(MAX_POINTS);
    localparam logic [CNT_W-1:0] MINP = CNT_W'(2);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]             r_state;
    logic [CNT_W-1:0]       r_k;
    logic [GAIN_W-1:0]      r_alpha;
    logic [GAIN_W-1:0]      r_beta;
    logic                   r_emit;
    logic [MAX_POINTS-1:0]  r_vld;

    logic                   r_rd_ok;
    logic                   r_rd_first;
    logic [AW-1:0]          r_rd_addr;
    logic                   r_rd_vld;
    logic                   r_erd;
    logic                   r_e_last;

    logic signed [Q_W-1:0]    r_prev;
    logic                     r_s2;
    logic [AW-1:0]            r_s2_addr;
    logic signed [Q_W-1:0]    r_s2_u;
    logic signed [Q_W-1:0]    r_s2_v;
    logic signed [PROD_W-1:0] r_pa;
    logic signed [PROD_W-1:0] r_pb;

    logic                   r_out_valid;
    logic [PIX_W-1:0]       r_out_index;
    logic signed [Q_W-1:0]  r_out_u;
    logic signed [Q_W-1:0]  r_out_v;
    logic                   r_out_last;

    logic [CNT_W-1:0]       n_eff;
    logic [CNT_W-1:0]       n_last;
    logic [CNT_W-1:0]       k_m1;
    logic                   load_wr;
    logic                   step_go;
    logic                   sw_issue;
    logic                   em_issue;
    logic                   rd_issue;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [DW-1:0]          ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [DW-1:0]          ram_rdata;
    logic signed [Q_W-1:0]  u_old;
    logic signed [Q_W-1:0]  v_old;
    logic signed [Q_W:0]    du;
    logic signed [Q_W:0]    dr;
    logic signed [PROD_W-1:0] pa;
    logic signed [PROD_W-1:0] pb;
    logic signed [SUM_W-1:0]  sum_u;
    logic signed [SUM_W-1:0]  sum_v;
    logic signed [Q_W-1:0]  new_u;
    logic signed [Q_W-1:0]  new_v;

    always_comb begin
        if (i_points > MAXP) begin
            n_eff = MAXP;
        end else if (i_points < MINP) begin
            n_eff = MINP;
        end else begin
            n_eff = i_points;
        end
    end
    assign n_last = n_eff - CNT_W'(1);
    assign k_m1   = r_k - CNT_W'(1);

    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;
    assign load_wr   = o_cmd_pop && (i_cmd.op == OP_LOAD);
    assign step_go   = o_cmd_pop && (i_cmd.op == OP_STEP);
    assign sw_issue  = (r_state == ST_SWEEP);
    assign em_issue  = (r_state == ST_EMIT) && (r_k < n_eff) && !r_erd
                       && (!r_out_valid || !i_out_stall);
    assign rd_issue  = sw_issue || em_issue;

    always_comb begin
        if (sw_issue) begin
            ram_raddr = (r_k == '0) ? n_last[AW-1:0] : k_m1[AW-1:0];
        end else begin
            ram_raddr = r_k[AW-1:0];
        end
    end

    // stage 1: old values back from the store
    assign u_old = r_rd_vld ? ram_rdata[DW-1:Q_W] : '0;
    assign v_old = r_rd_vld ? ram_rdata[Q_W-1:0] : '0;
    assign du    = {u_old[Q_W-1], u_old} - {r_prev[Q_W-1], r_prev};
    assign dr    = {u_old[Q_W-1], u_old} - {v_old[Q_W-1], v_old};
    assign pa    = du * $signed({1'b0, r_alpha});
    assign pb    = dr * $signed({1'b0, r_beta});

    // stage 2: floor shift, subtract (u) or add (v), saturate
    assign sum_u = SUM_W'(r_s2_u) - SUM_W'(r_pa >>> GAIN_W);
    assign sum_v = SUM_W'(r_s2_v) + SUM_W'(r_pb >>> GAIN_W);
    assign new_u = sat_q(sum_u);
    assign new_v = sat_q(sum_v);

    assign ram_we    = r_s2 || load_wr;
    assign ram_waddr = r_s2 ? r_s2_addr : i_cmd.idx[AW-1:0];
    assign ram_wdata = r_s2 ? {new_u, new_v} : {i_cmd.u, i_cmd.v};

    puas_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_POINTS)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_vld       <= '0;
            r_rd_ok     <= 1'b0;
            r_erd       <= 1'b0;
            r_s2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            r_rd_ok <= sw_issue;
            r_erd   <= em_issue;
            r_s2    <= r_rd_ok && !r_rd_first;

            if (r_erd) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (step_go) begin
                        r_k     <= '0;
                        r_state <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    if (r_k == n_eff) begin
                        r_state <= ST_FLUSH;
                    end
                    r_k <= r_k + CNT_W'(1);
                end
                ST_FLUSH: begin
                    if (!r_rd_ok && !r_s2) begin
                        r_k     <= '0;
                        r_state <= r_emit ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (em_issue) begin
                        r_k <= r_k + CNT_W'(1);
                    end else if ((r_k == n_eff) && !r_erd) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_alpha <= i_cmd.alpha;
            r_beta  <= i_cmd.beta;
            r_emit  <= i_cmd.emit;
        end
        if (rd_issue) begin
            r_rd_first <= sw_issue && (r_k == '0);
            r_rd_addr  <= ram_raddr;
            r_rd_vld   <= r_vld[ram_raddr];
            r_e_last   <= (r_k == n_last);
        end
        if (r_rd_ok) begin
            r_prev    <= u_old;
            r_s2_addr <= r_rd_addr;
            r_s2_u    <= u_old;
            r_s2_v    <= v_old;
            r_pa      <= pa;
            r_pb      <= pb;
        end
        if (r_erd) begin
            r_out_index <= PIX_W'(r_rd_addr);
            r_out_u     <= u_old;
            r_out_v     <= v_old;
            r_out_last  <= r_e_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_index  = r_out_index;
    assign o_out_u      = r_out_u;
    assign o_out_v      = r_out_v;
    assign o_last_point = r_out_last;

    a_reads_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_rd_ok && r_erd))
        else $error("sweep and stream reads overlap");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_erd |-> !r_out_valid)
        else $error("streamed point arrives while output register is full");

    a_s2_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2 |-> (r_state == ST_SWEEP || r_state == ST_FLUSH))
        else $error("update write outside a sweep");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_point) |-> (o_out_index == n_last[PIX_W-1:0]))
        else $error("last point flag on wrong index");

endmodule

// File: rtl/core/periodic_upwind_advection_step.sv
// Top level of the periodic upwind advection step: config register, front, back.
// Depends on puas_pkg, puas_front, puas_back, puas_ram.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+---------------------------------------------
//  input    | i_in_valid / o_in_stall       | opcode, point_index, load_u/v, gains, emit
//  output   | o_out_valid / i_out_stall     | out_index, out_u, out_v, last_point
//  config   | psel, penable, pwrite, pready | paddr, pwdata, prdata (points_in_use at 0)
//
// A load writes the grid store when its command is popped. A step sweeps the store
// once, n + 1 reads one per cycle, then drains its pipeline (n = clamped point count);
// with emit set, points then stream, one store read at a time, held back by i_out_stall.
// After reset the grid reads as zero through per-entry valid bits; no clearing pass.
// A two-entry command queue lets input transfers continue while the back end works.
module periodic_upwind_advection_step #(
    parameter int MAX_POINTS = puas_pkg::DEF_MAX_POINTS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_opcode,
    input  logic [puas_pkg::PIX_W-1:0]           i_point_index,
    input  logic signed [puas_pkg::Q_W-1:0]      i_load_u,
    input  logic signed [puas_pkg::Q_W-1:0]      i_load_v,
    input  logic [puas_pkg::GAIN_W-1:0]          i_advect_gain,
    input  logic [puas_pkg::GAIN_W-1:0]          i_relax_gain,
    input  logic                                 i_emit_after,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [puas_pkg::PIX_W-1:0]           o_out_index,
    output logic signed [puas_pkg::Q_W-1:0]      o_out_u,
    output logic signed [puas_pkg::Q_W-1:0]      o_out_v,
    output logic                                 o_last_point,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [puas_pkg::APB_AW-1:0]          paddr,
    input  logic [puas_pkg::APB_DW-1:0]          pwdata,
    output logic [puas_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready
);
    import puas_pkg::*;

    logic [CNT_W-1:0] r_points;
    logic             cfg_wr;
    logic             cmd_valid;
    t_cmd             cmd;
    logic             cmd_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_POINTS);
    assign prdata = (paddr[2] == REG_POINTS) ? APB_DW'(r_points) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= POINTS_RST;
        end else if (cfg_wr) begin
            r_points <= pwdata[CNT_W-1:0];
        end
    end

    puas_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_opcode      (i_opcode),
        .i_point_index (i_point_index),
        .i_load_u      (i_load_u),
        .i_load_v      (i_load_v),
        .i_advect_gain (i_advect_gain),
        .i_relax_gain  (i_relax_gain),
        .i_emit_after  (i_emit_after),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    puas_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_points     (r_points),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_index  (o_out_index),
        .o_out_u      (o_out_u),
        .o_out_v      (o_out_v),
        .o_last_point (o_last_point)
    );

endmodule
